// ----- src/tcr_pkg.sv -----
// shared types, constants and the temperature table builder
package tcr_pkg;

    localparam int PERIOD_BITS = 16;
    localparam int ADC_BITS    = 10;
    localparam int MAX_LINE    = 256;
    localparam int POS_BITS    = $clog2(MAX_LINE) + 1;
    localparam int ADC_DEPTH   = 1 << ADC_BITS;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int KW_COUNT    = 7;
    localparam int TEMP_BITS   = 14;
    localparam int ROM_BITS    = 2 * TEMP_BITS + 1;

    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};
    localparam logic [ADC_BITS-1:0]    ADC_MAX    = {ADC_BITS{1'b1}};

    // output kinds
    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_SHUT   = 2'd2;

    // command codes, also keyword indexes
    localparam logic [2:0] CMD_SCALE_F = 3'd0;
    localparam logic [2:0] CMD_SCALE_C = 3'd1;
    localparam logic [2:0] CMD_START   = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_OFF     = 3'd4;
    localparam logic [2:0] CMD_PERIOD  = 3'd5;
    localparam logic [2:0] CMD_LOG     = 3'd6;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // keywords, left aligned, padding never compared
    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        "SCALE=F", "SCALE=C", "START  ", "STOP   ", "OFF    ", "PERIOD=", "LOG    "
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd7, 3'd7, 3'd5, 3'd4, 3'd3, 3'd7, 3'd3};

    typedef enum logic [1:0] {
        PH_BLANK,
        PH_TEXT,
        PH_DROP
    } phase_t;

    typedef enum logic [1:0] {
        JOB_CMD,
        JOB_REPORT,
        JOB_OFF
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [2:0]        command;
        logic [ADC_BITS-1:0] sample;
        logic              celsius;
    } job_t;

    typedef logic [ROM_BITS-1:0] rom_t [ADC_DEPTH];

    // fixed point constants of the conversion
    localparam longint LnTwoQ32  = 64'sd2977044472;
    localparam longint BetaScale = 64'sd4275 * 64'sd256;
    localparam longint InvT0Q48  = ((64'sd1 <<< 48) * 64'sd100) / 64'sd29815;
    localparam longint OffsetQ15 = 64'sd27315 * 64'sd32768;
    localparam longint CelDivQ15 = 64'sd10 * 64'sd32768;
    localparam longint FahAddQ15 = 64'sd16000 * 64'sd32768;
    localparam longint FahDivQ15 = 64'sd50 * 64'sd32768;
    localparam longint DMin      = 64'sd1 <<< 20;

    // log2 in Q24 by repeated squaring
    function automatic logic [63:0] log2_q24(input logic [31:0] x);
        logic [5:0]  k;
        logic [63:0] m;
        logic [23:0] frac;
        k = 6'd0;
        for (int j = 1; j <= 30; j++) begin
            if ((x >> j) != 32'd0)
                k = j[5:0];
        end
        m = {32'd0, x} << (6'd30 - k);
        frac = 24'd0;
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = {frac[22:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return ({58'd0, k} << 24) + {40'd0, frac};
    endfunction

    function automatic longint sat_temp(input longint t);
        if (t < -64'sd1000)
            return -64'sd1000;
        if (t > 64'sd6000)
            return 64'sd6000;
        return t;
    endfunction

    // {fault, fahrenheit tenths, celsius tenths} for one sample
    function automatic logic [ROM_BITS-1:0] temp_entry(input logic [ADC_BITS-1:0] s);
        longint      l2;
        longint      d;
        longint      kq;
        longint      c100;
        longint      tc;
        longint      tf;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] dv;
        logic [63:0] num;
        if (s == '0 || s == ADC_MAX)
            return {1'b1, {(2 * TEMP_BITS){1'b0}}};
        l2 = longint'(log2_q24(32'(ADC_MAX - s))) - longint'(log2_q24(32'(s)));
        d = l2 * LnTwoQ32 / BetaScale + InvT0Q48;
        if (d < DMin)
            d = DMin;
        dv = 64'(d);
        num = 64'h8000_0000_0000_0000;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= dv) begin
                r = r - dv;
                q[i] = 1'b1;
            end
        end
        kq = longint'(q);
        c100 = kq * 64'sd100 - OffsetQ15;
        tc = sat_temp(c100 / CelDivQ15);
        tf = sat_temp((c100 * 64'sd9 + FahAddQ15) / FahDivQ15);
        return {1'b0, tf[TEMP_BITS-1:0], tc[TEMP_BITS-1:0]};
    endfunction

    function automatic rom_t build_rom();
        rom_t rom;
        for (int s = 0; s < ADC_DEPTH; s++)
            rom[s] = temp_entry(s[ADC_BITS-1:0]);
        return rom;
    endfunction

endpackage

// ----- src/tcr_in_if.sv -----
// request channel carrying command bytes and ticks
interface tcr_in_if;
    import tcr_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [7:0]          data_byte;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output mode, output data_byte, output adc_sample,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input adc_sample,
                    output ready);
endinterface

// ----- src/tcr_out_if.sv -----
// result channel carrying command, shutdown and temperature results
interface tcr_out_if;
    import tcr_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [2:0]                  command;
    logic signed [TEMP_BITS-1:0] temperature_tenths;
    logic                        in_celsius;
    logic                        sensor_fault;
    logic                        last;

    modport source (output valid, output kind, output command, output temperature_tenths,
                    output in_celsius, output sensor_fault, output last, input ready);
    modport sink   (input valid, input kind, input command, input temperature_tenths,
                    input in_celsius, input sensor_fault, input last, output ready);
endinterface

// ----- src/thermistor_command_reporter.sv -----
// top level of the thermistor command reporter
// The block takes one request per clock on in_ch while in_ch.ready is high: a command
// byte (mode 0) or a one-second tick carrying a converter sample (mode 1). The front
// parser handles every item in the cycle it is accepted, skipping leading blanks,
// matching the keywords byte by byte and running the report countdown; a newline that
// completes SCALE=F, SCALE=C, START, STOP, OFF, a valid PERIOD= line or a LOG line,
// and every tick that ends the countdown with reporting on, puts one job into a
// four-deep queue. The result stage pops a job, reads the 1024-entry temperature
// table (built at elaboration, registered read) and sends one result per cycle on
// out_ch while out_ch is ready; OFF sends two results, and once the OFF line is
// parsed the block ignores all input until reset. in_ch.ready drops only while the
// queue is full, so with out_ch always ready the block sustains one request per
// cycle, and a result appears once its job has passed the queue and output registers.
module thermistor_command_reporter (
    input  logic      clk,
    input  logic      rst_n,
    tcr_in_if.sink    in_ch,
    tcr_out_if.source out_ch
);
    import tcr_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head_job;

    // parser and control state
    tcr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // decouples parsing from result delivery
    tcr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    // lookup and output register
    tcr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head_job (head_job),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

// ----- src/tcr_front.sv -----
// line parser, tick countdown and control state
module tcr_front (
    input  logic          clk,
    input  logic          rst_n,
    tcr_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          push,
    output tcr_pkg::job_t push_job
);
    import tcr_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [KW_COUNT-1:0]    cand_reg, cand_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [PERIOD_BITS-1:0] acc_reg, acc_next;
    logic                   derr_reg, derr_next;
    logic [PERIOD_BITS-1:0] period_reg, period_next;
    logic                   cel_reg, cel_next;
    logic                   rep_on_reg, rep_on_next;
    logic [PERIOD_BITS-1:0] ttw_reg, ttw_next;
    logic                   halted_reg, halted_next;

    logic                   take;
    logic [7:0]             c;
    logic                   is_blank;
    logic                   is_digit;
    logic [PERIOD_BITS+3:0] acc_mul;
    logic [PERIOD_BITS-1:0] acc_step;
    logic [2:0]             p3;
    logic                   exact_hit;

    assign in_ch.ready = !q_full;
    assign take        = in_ch.valid && !q_full;
    assign c           = in_ch.data_byte;
    assign is_blank    = (c == CH_SPACE) || (c == CH_TAB);
    assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
    assign acc_mul     = ({4'd0, acc_reg} * (PERIOD_BITS+4)'(10))
                         + (PERIOD_BITS+4)'(c - CH_ZERO);
    assign acc_step    = (acc_mul > (PERIOD_BITS+4)'(PERIOD_MAX)) ? PERIOD_MAX
                                                                  : acc_mul[PERIOD_BITS-1:0];
    assign p3          = pos_reg[2:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg  <= PH_BLANK;
            cand_reg   <= '1;
            pos_reg    <= '0;
            acc_reg    <= '0;
            derr_reg   <= 1'b0;
            period_reg <= PERIOD_BITS'(1);
            cel_reg    <= 1'b0;
            rep_on_reg <= 1'b1;
            ttw_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else begin
            phase_reg  <= phase_next;
            cand_reg   <= cand_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            derr_reg   <= derr_next;
            period_reg <= period_next;
            cel_reg    <= cel_next;
            rep_on_reg <= rep_on_next;
            ttw_reg    <= ttw_next;
            halted_reg <= halted_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        cand_next   = cand_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        derr_next   = derr_reg;
        period_next = period_reg;
        cel_next    = cel_reg;
        rep_on_next = rep_on_reg;
        ttw_next    = ttw_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        exact_hit   = 1'b0;
        push_job.kind    = JOB_CMD;
        push_job.command = CMD_SCALE_F;
        push_job.sample  = in_ch.adc_sample;
        push_job.celsius = cel_reg;

        if (take && !halted_reg) begin
            if (in_ch.mode) begin
                if (rep_on_reg && ttw_reg <= PERIOD_BITS'(1)) begin
                    push          = 1'b1;
                    push_job.kind = JOB_REPORT;
                    ttw_next      = period_reg;
                end
                else if (ttw_reg != '0) begin
                    ttw_next = ttw_reg - PERIOD_BITS'(1);
                end
            end
            else if (c == CH_NEWLINE) begin
                if (phase_reg == PH_TEXT) begin
                    // exact keywords first, in list order
                    for (int i = KW_COUNT - 3; i >= 0; i--) begin
                        if (cand_reg[i] && pos_reg == POS_BITS'(KW_LEN[i])) begin
                            exact_hit        = 1'b1;
                            push_job.command = 3'(i);
                        end
                    end
                    if (exact_hit) begin
                        push = 1'b1;
                        case (push_job.command)
                            CMD_SCALE_F: cel_next = 1'b0;
                            CMD_SCALE_C: cel_next = 1'b1;
                            CMD_START:   rep_on_next = 1'b1;
                            CMD_STOP:    rep_on_next = 1'b0;
                            CMD_OFF:
                            begin
                                push_job.kind = JOB_OFF;
                                halted_next   = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    else if (cand_reg[CMD_PERIOD]
                             && pos_reg >= POS_BITS'(KW_LEN[CMD_PERIOD])) begin
                        if (!derr_reg) begin
                            push             = 1'b1;
                            push_job.command = CMD_PERIOD;
                            if (pos_reg > POS_BITS'(KW_LEN[CMD_PERIOD]))
                                period_next = acc_reg;
                        end
                    end
                    else if (cand_reg[CMD_LOG] && pos_reg >= POS_BITS'(KW_LEN[CMD_LOG])) begin
                        push             = 1'b1;
                        push_job.command = CMD_LOG;
                    end
                end
                phase_next = PH_BLANK;
                cand_next  = '1;
                pos_next   = '0;
                acc_next   = '0;
                derr_next  = 1'b0;
            end
            else if (phase_reg == PH_TEXT || (phase_reg == PH_BLANK && !is_blank)) begin
                phase_next = PH_TEXT;
                if (pos_reg >= POS_BITS'(MAX_LINE - 1)) begin
                    phase_next = PH_DROP;
                end
                else begin
                    for (int i = 0; i < KW_COUNT; i++) begin
                        if (cand_reg[i]) begin
                            if (pos_reg < POS_BITS'(KW_LEN[i])) begin
                                if (KW_TEXT[i][(6 - int'(p3)) * 8 +: 8] != c)
                                    cand_next[i] = 1'b0;
                            end
                            else if (i < int'(CMD_PERIOD)) begin
                                cand_next[i] = 1'b0;
                            end
                            else if (i == int'(CMD_PERIOD)) begin
                                if (is_digit)
                                    acc_next = acc_step;
                                else
                                    derr_next = 1'b1;
                            end
                        end
                    end
                    pos_next = pos_reg + POS_BITS'(1);
                end
            end
        end
    end

endmodule

// ----- src/tcr_fifo.sv -----
// short job queue between parser and result stage
module tcr_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcr_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output tcr_pkg::job_t head_job
);
    import tcr_pkg::*;

    job_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (FIFO_AW+1)'(1);
        end
    end

endmodule

// ----- src/tcr_back.sv -----
// result stage: temperature lookup and result sequencing
module tcr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  tcr_pkg::job_t head_job,
    output logic          pop,
    tcr_out_if.source     out_ch
);
    import tcr_pkg::*;

    localparam rom_t TEMP_ROM = build_rom();

    logic                valid_reg;
    job_t                job_reg;
    logic                second_reg;
    logic [ROM_BITS-1:0] rom_reg;
    logic                done;

    // an off job sends a command result and then the shutdown result
    assign done = out_ch.ready && (job_reg.kind != JOB_OFF || second_reg);
    assign pop  = !q_empty && (!valid_reg || done);

    always_ff @(posedge clk) begin
        if (pop) begin
            job_reg <= head_job;
            rom_reg <= TEMP_ROM[head_job.sample];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else begin
            if (pop) begin
                valid_reg  <= 1'b1;
                second_reg <= 1'b0;
            end
            else if (valid_reg && out_ch.ready) begin
                if (done)
                    valid_reg <= 1'b0;
                else
                    second_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        out_ch.valid              = valid_reg;
        out_ch.kind               = KIND_CMD;
        out_ch.command            = job_reg.command;
        out_ch.temperature_tenths = '0;
        out_ch.in_celsius         = 1'b0;
        out_ch.sensor_fault       = 1'b0;
        out_ch.last               = 1'b1;
        case (job_reg.kind)
            JOB_REPORT:
            begin
                out_ch.kind               = KIND_REPORT;
                out_ch.command            = CMD_SCALE_F;
                out_ch.in_celsius         = job_reg.celsius;
                out_ch.sensor_fault       = rom_reg[ROM_BITS-1];
                out_ch.temperature_tenths = job_reg.celsius ? rom_reg[TEMP_BITS-1:0]
                                                : rom_reg[2*TEMP_BITS-1:TEMP_BITS];
            end
            JOB_OFF:
            begin
                out_ch.command = CMD_OFF;
                out_ch.kind    = second_reg ? KIND_SHUT : KIND_CMD;
                out_ch.last    = second_reg;
            end
            default: ;
        endcase
    end

endmodule
